// ----- hdl/richardson_iterative_solver_core_macros.svh -----
// Assertion macros shared by the solver RTL.
`ifndef RICHARDSON_ITERATIVE_SOLVER_CORE_MACROS_SVH
`define RICHARDSON_ITERATIVE_SOLVER_CORE_MACROS_SVH

`ifndef SYNTH
// The expression must never hold outside reset.
`define RSC_ASSERT_NEVER(name, clk, rst_n, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
// The antecedent implies the consequent in the same cycle.
`define RSC_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// The antecedent implies the consequent in the next cycle.
`define RSC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RSC_ASSERT_NEVER(name, clk, rst_n, expr, msg)
`define RSC_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)
`define RSC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- hdl/rsc_pkg.sv -----
package rsc_pkg;

  // Vector length and index widths.
  localparam int DIM    = 64;
  localparam int IDX_W  = 6;
  localparam int ADDR_W = 2 * IDX_W;

  // Q16.32 data path.
  localparam int DATA_W = 48;
  localparam int HALF_W = DATA_W / 2;
  localparam int ACC_W  = 56;
  localparam int TOL_W  = 47;
  localparam int ITER_W = 32;

  localparam logic signed [DATA_W-1:0] MAX_DATA = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MIN_DATA = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [TOL_W-1:0]         MAX_CHG  = {TOL_W{1'b1}};

  // Input item kinds.
  localparam logic [1:0] KIND_MATRIX = 2'd0;
  localparam logic [1:0] KIND_RHS    = 2'd1;
  localparam logic [1:0] KIND_START  = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd2;

  // Reset values of the configuration registers.
  localparam logic signed [DATA_W-1:0] STEP_RESET  = 48'sd21475;
  localparam logic [TOL_W-1:0]         TOL_RESET   = 47'd429;
  localparam logic [ITER_W-1:0]        LIMIT_RESET = 32'd100000000;

  // Controls that every cell of the vector chain receives.
  typedef struct packed {
    logic clear;
    logic copy;
    logic rotate;
    logic push;
  } cell_ctl_t;

endpackage

// ----- hdl/rsc_cell.sv -----
module rsc_cell (
  input  logic                             clk,
  input  rsc_pkg::cell_ctl_t               ctl,
  input  logic signed [rsc_pkg::DATA_W-1:0] cur_in,
  input  logic signed [rsc_pkg::DATA_W-1:0] nxt_in,
  output logic signed [rsc_pkg::DATA_W-1:0] cur_out,
  output logic signed [rsc_pkg::DATA_W-1:0] nxt_out
);
  import rsc_pkg::*;

  logic signed [DATA_W-1:0] cur_r;
  logic signed [DATA_W-1:0] nxt_r;

  // Current element: cleared at start, loaded from the new sweep, or passed along the ring.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      cur_r <= '0;
    end else if (ctl.copy) begin
      cur_r <= nxt_r;
    end else if (ctl.rotate) begin
      cur_r <= cur_in;
    end
    if (ctl.push) begin
      nxt_r <= nxt_in;
    end
  end

  assign cur_out = cur_r;
  assign nxt_out = nxt_r;

endmodule

// ----- hdl/rsc_qmul.sv -----
module rsc_qmul (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic signed [rsc_pkg::DATA_W-1:0] in_a,
  input  logic signed [rsc_pkg::DATA_W-1:0] in_b,
  output logic                              out_valid,
  output logic signed [rsc_pkg::DATA_W-1:0] out_p
);
  import rsc_pkg::*;

  localparam int PROD_W = 2 * DATA_W;
  localparam int SHR_W  = PROD_W - 32;

  logic [3:0]              vld_r;
  logic                    neg1_r, neg2_r, neg3_r;
  logic [DATA_W-1:0]       ma_r, mb_r;
  logic [DATA_W-1:0]       pp_hh_r, pp_hl_r, pp_lh_r, pp_ll_r;
  logic [SHR_W-1:0]        shr_r;
  logic signed [DATA_W-1:0] p_r;
  logic [PROD_W-1:0]       sum_w;

  // Full magnitude product from four half-width partial products.
  assign sum_w = {pp_hh_r, {DATA_W{1'b0}}}
               + {{HALF_W{1'b0}}, pp_hl_r, {HALF_W{1'b0}}}
               + {{HALF_W{1'b0}}, pp_lh_r, {HALF_W{1'b0}}}
               + {{DATA_W{1'b0}}, pp_ll_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_valid};
    end
    // Stage one: magnitudes and result sign.
    ma_r   <= in_a[DATA_W-1] ? (~in_a + 1'b1) : in_a;
    mb_r   <= in_b[DATA_W-1] ? (~in_b + 1'b1) : in_b;
    neg1_r <= in_a[DATA_W-1] ^ in_b[DATA_W-1];
    // Stage two: partial products.
    pp_hh_r <= ma_r[DATA_W-1:HALF_W] * mb_r[DATA_W-1:HALF_W];
    pp_hl_r <= ma_r[DATA_W-1:HALF_W] * mb_r[HALF_W-1:0];
    pp_lh_r <= ma_r[HALF_W-1:0] * mb_r[DATA_W-1:HALF_W];
    pp_ll_r <= ma_r[HALF_W-1:0] * mb_r[HALF_W-1:0];
    neg2_r  <= neg1_r;
    // Stage three: sum and drop the fraction bits (truncation toward zero).
    shr_r  <= sum_w[PROD_W-1:32];
    neg3_r <= neg2_r;
    // Stage four: apply the sign and saturate.
    if (neg3_r) begin
      if (shr_r >= SHR_W'({1'b1, {(DATA_W-1){1'b0}}})) begin
        p_r <= MIN_DATA;
      end else begin
        p_r <= -$signed(shr_r[DATA_W-1:0]);
      end
    end else begin
      if (shr_r > SHR_W'(MAX_DATA)) begin
        p_r <= MAX_DATA;
      end else begin
        p_r <= $signed(shr_r[DATA_W-1:0]);
      end
    end
  end

  assign out_valid = vld_r[3];
  assign out_p     = p_r;

endmodule

// ----- hdl/richardson_iterative_solver_core.sv -----
// Richardson iteration solver for a DIM-by-DIM system in Q16.32 fixed point.
// Input channel (in_*): kind in in_tuser selects a matrix load, a right-hand
// load or a start. Loads are taken one per cycle while the block is idle.
// A start clears x and runs sweeps x = x - tau*(A*x - b) until the largest
// change per sweep drops below the tolerance or to zero, or the sweep limit is reached.
// The pace of each row is set by the one shared pipelined multiplier, which
// takes one product of a row sum per cycle and then the tau product; each
// sweep closes with an end state after its DIM rows.
// The vector x lives in a ring of cells that rotates one element per product.
// Output channel (out_*): DIM transfers of index and solution, converged in
// out_tuser and out_tlast on the final element, one per cycle unless the
// receiver stalls; a stall holds the current element and the whole block.
// No input is accepted from start until the last element is taken.
// Configuration (cfg_*) is always ready and is written while idle; the block does not enforce this.
// Reset restores the register defaults and returns to idle; matrix and
// right-hand stores keep no reset value and must be written before use.
module richardson_iterative_solver_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input items.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [63:0]                          in_tdata,   // row[5:0], col[11:6], value[59:12]
  input  logic [1:0]                           in_tuser,   // kind[1:0]
  // Result items.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [55:0]                          out_tdata,  // index[5:0], solution[53:6]
  output logic                                 out_tuser,  // converged[0]
  output logic                                 out_tlast,
  // Register writes.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rsc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rsc_pkg::DATA_W-1:0]           cfg_data
);
  import rsc_pkg::*;

`include "richardson_iterative_solver_core_macros.svh"

  typedef enum logic [3:0] {
    ST_IDLE, ST_ISSUE, ST_DRAIN, ST_TAU, ST_TAU_WAIT, ST_UPD, ST_SWEEP_END, ST_EMIT
  } state_t;

  localparam int WIDE_W = ACC_W + 1;

  // Saturate a wide signed value to the data width.
  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [WIDE_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > WIDE_W'(MAX_DATA)) begin
      r = MAX_DATA;
    end else if (v < WIDE_W'(MIN_DATA)) begin
      r = MIN_DATA;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // Input field views.
  logic [IDX_W-1:0]         in_row, in_col;
  logic signed [DATA_W-1:0] in_value;
  logic                     in_fire, out_fire;

  assign in_row   = in_tdata[5:0];
  assign in_col   = in_tdata[11:6];
  assign in_value = in_tdata[59:12];

  // Configuration registers.
  logic signed [DATA_W-1:0] step_r;
  logic [TOL_W-1:0]         tol_r;
  logic [ITER_W-1:0]        limit_r;

  // Stores.
  logic [DATA_W-1:0]        mat_mem [0:(1 << ADDR_W)-1];
  logic [DATA_W-1:0]        rhs_mem [0:(1 << IDX_W)-1];
  logic signed [DATA_W-1:0] mrd_r, rhs_rd_r;

  // Control and data path registers.
  state_t                   state_r, state_nxt;
  logic [IDX_W-1:0]         row_r, row_nxt, j_r, j_nxt, idx_r, idx_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic [IDX_W:0]           cnt_r, cnt_nxt;
  logic signed [DATA_W-1:0] xi_r, xi_nxt, xn_r, xn_nxt, xd_r, xd_nxt, ws_r, ws_nxt;
  logic [TOL_W-1:0]         chg_r, chg_nxt, prev_r, prev_nxt;
  logic [ITER_W-1:0]        iter_r, iter_nxt;
  logic                     conv_r, conv_nxt, issue_r, issue_nxt;

  // Cell chain and multiplier hookup.
  cell_ctl_t                ctl;
  logic signed [DATA_W-1:0] cur_w [DIM];
  logic signed [DATA_W-1:0] nxt_w [DIM];
  logic signed [DATA_W-1:0] head;
  logic                     mul_iv, mul_ov;
  logic signed [DATA_W-1:0] mul_a, mul_b, mul_p, acc_s;
  logic signed [DATA_W:0]   dv;
  logic [DATA_W:0]          dmag;
  logic [TOL_W-1:0]         dsat;

  assign head      = cur_w[0];
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;

  // Ring of cells holding the current and next vector.
  for (genvar k = 0; k < DIM; k++) begin : g_cell
    rsc_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .cur_in  (cur_w[(k + 1) % DIM]),
      .nxt_in  ((k == DIM - 1) ? xn_r : nxt_w[(k + 1) % DIM]),
      .cur_out (cur_w[k]),
      .nxt_out (nxt_w[k])
    );
  end

  // Row sum minus b, then the shared multiplier takes either a row term or tau.
  assign acc_s  = sat_data(WIDE_W'(acc_r) - WIDE_W'(rhs_rd_r));
  assign mul_iv = issue_r || (state_r == ST_TAU);
  assign mul_a  = (state_r == ST_TAU) ? ws_r : mrd_r;
  assign mul_b  = (state_r == ST_TAU) ? acc_s : xd_r;

  rsc_qmul u_qmul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mul_iv),
    .in_a      (mul_a),
    .in_b      (mul_b),
    .out_valid (mul_ov),
    .out_p     (mul_p)
  );

  // Absolute change of the element just updated.
  assign dv   = (DATA_W + 1)'(xn_r) - (DATA_W + 1)'(xi_r);
  assign dmag = dv[DATA_W] ? (DATA_W + 1)'(-dv) : (DATA_W + 1)'(dv);
  assign dsat = (dmag > (DATA_W + 1)'(MAX_CHG)) ? MAX_CHG : dmag[TOL_W-1:0];

  // Stores: writes from load transfers, registered reads for the solve.
  always_ff @(posedge clk) begin
    if (in_fire && in_tuser == KIND_MATRIX) begin
      mat_mem[{in_row, in_col}] <= in_value;
    end
    if (in_fire && in_tuser == KIND_RHS) begin
      rhs_mem[in_row] <= in_value;
    end
    mrd_r    <= mat_mem[{row_r, j_r}];
    rhs_rd_r <= rhs_mem[row_r];
  end

  // Next-state logic of the sweep sequencer.
  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    j_nxt     = j_r;
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    xi_nxt    = xi_r;
    xn_nxt    = xn_r;
    xd_nxt    = xd_r;
    ws_nxt    = ws_r;
    chg_nxt   = chg_r;
    prev_nxt  = prev_r;
    iter_nxt  = iter_r;
    conv_nxt  = conv_r;
    issue_nxt = 1'b0;
    ctl       = '0;
    // Row terms come out of the multiplier during issue and drain.
    if (mul_ov && (state_r == ST_ISSUE || state_r == ST_DRAIN)) begin
      acc_nxt = acc_r + ACC_W'(mul_p);
      cnt_nxt = cnt_r + 1'b1;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_tuser == KIND_START) begin
          ctl.clear = 1'b1;
          prev_nxt  = MAX_CHG;
          ws_nxt    = step_r;
          iter_nxt  = '0;
          row_nxt   = '0;
          j_nxt     = '0;
          idx_nxt   = '0;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          chg_nxt   = '0;
          conv_nxt  = 1'b0;
          state_nxt = (limit_r == '0) ? ST_EMIT : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        issue_nxt  = 1'b1;
        xd_nxt     = head;
        ctl.rotate = 1'b1;
        if (j_r == row_r) begin
          xi_nxt = head;
        end
        if (j_r == IDX_W'(DIM - 1)) begin
          j_nxt     = '0;
          state_nxt = ST_DRAIN;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (cnt_r == (IDX_W + 1)'(DIM)) begin
          state_nxt = ST_TAU;
        end
      end
      ST_TAU: begin
        state_nxt = ST_TAU_WAIT;
      end
      ST_TAU_WAIT: begin
        if (mul_ov) begin
          xn_nxt    = sat_data(WIDE_W'(xi_r) - WIDE_W'(mul_p));
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        ctl.push = 1'b1;
        if (dsat > chg_r) begin
          chg_nxt = dsat;
        end
        acc_nxt = '0;
        cnt_nxt = '0;
        if (row_r == IDX_W'(DIM - 1)) begin
          state_nxt = ST_SWEEP_END;
        end else begin
          row_nxt   = row_r + 1'b1;
          state_nxt = ST_ISSUE;
        end
      end
      ST_SWEEP_END: begin
        // Flip the sign of tau when the change grew.
        if (chg_r > prev_r) begin
          ws_nxt = (ws_r == MIN_DATA) ? MAX_DATA : -ws_r;
        end
        prev_nxt = chg_r;
        row_nxt  = '0;
        chg_nxt  = '0;
        if (chg_r < tol_r) begin
          conv_nxt  = 1'b1;
          state_nxt = ST_EMIT;
        end else if (chg_r == '0) begin
          state_nxt = ST_EMIT;
        end else begin
          ctl.copy = 1'b1;
          iter_nxt = iter_r + 1'b1;
          if ((ITER_W + 1)'(iter_r) + 1'b1 == (ITER_W + 1)'(limit_r)) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          ctl.rotate = 1'b1;
          idx_nxt    = idx_r + 1'b1;
          if (idx_r == IDX_W'(DIM - 1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, configuration and data path registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      issue_r <= 1'b0;
      step_r  <= STEP_RESET;
      tol_r   <= TOL_RESET;
      limit_r <= LIMIT_RESET;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      issue_r <= issue_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STEP:  step_r  <= cfg_data;
          REG_TOL:   tol_r   <= cfg_data[TOL_W-1:0];
          REG_LIMIT: limit_r <= cfg_data[ITER_W-1:0];
          default:   ;
        endcase
      end
    end
    row_r  <= row_nxt;
    j_r    <= j_nxt;
    idx_r  <= idx_nxt;
    acc_r  <= acc_nxt;
    xi_r   <= xi_nxt;
    xn_r   <= xn_nxt;
    xd_r   <= xd_nxt;
    ws_r   <= ws_nxt;
    chg_r  <= chg_nxt;
    prev_r <= prev_nxt;
    iter_r <= iter_nxt;
    conv_r <= conv_nxt;
  end

  // Result channel straight from the ring head.
  assign out_tvalid = (state_r == ST_EMIT);
  assign out_tdata  = {2'b00, head, idx_r};
  assign out_tuser  = conv_r;
  assign out_tlast  = (idx_r == IDX_W'(DIM - 1));

  // Checks on the sequencer.
  `RSC_ASSERT_NEVER(a_no_overlap, clk, rst_n, in_tready && out_tvalid, "input and output active together")
  `RSC_ASSERT_NEVER(a_cnt_bound, clk, rst_n, cnt_r > (IDX_W + 1)'(DIM), "too many row terms")
  `RSC_ASSERT_IMPL(a_mul_busy, clk, rst_n, mul_ov, state_r == ST_ISSUE || state_r == ST_DRAIN || state_r == ST_TAU_WAIT, "product outside a row")
  `RSC_ASSERT_NEXT(a_last_idle, clk, rst_n, out_fire && out_tlast, in_tready, "not idle after the last element")

endmodule
